>>> design/snru_pkg.sv
// shared types, codes and the update rule function for the signed network rule update block
package snru_pkg;

   localparam int NODES_DEF = 10;
   localparam int NODES_MAX = 16;
   localparam int NODE_W    = 4;
   localparam int ROW_W     = 10;
   localparam int RULE_W    = 2;

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_STEP  = 2'd1,
      KIND_READ  = 2'd2
   } kind_type;

   typedef enum logic [RULE_W-1:0] {
      RULE_4 = 2'd0,
      RULE_6 = 2'd1,
      RULE_7 = 2'd2,
      RULE_8 = 2'd3
   } rule_type;

   typedef enum logic [1:0] {
      SEQ_IDLE = 2'd0,
      SEQ_EXEC = 2'd1,
      SEQ_SCAN = 2'd2
   } seq_state_type;

   typedef enum logic [1:0] {
      LANE_HOLD   = 2'd0,
      LANE_WRITE  = 2'd1,
      LANE_UPDATE = 2'd2,
      LANE_CHECK  = 2'd3
   } lane_op_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [NODE_W-1:0] node_a;
      logic [NODE_W-1:0] node_b;
      logic              sign_bit;
   } req_type;

   typedef struct packed {
      logic             absorbing;
      logic [ROW_W-1:0] row_bits;
   } rsp_type;

   typedef struct packed {
      lane_op_type       op;
      rule_type          rule;
      logic [NODE_W-1:0] sel_a;
      logic [NODE_W-1:0] sel_b;
      logic              sign_bit;
   } lane_ctrl_type;

   typedef struct packed {
      logic [NODES_MAX-1:0] row;
      logic                 mismatch;
   } lane_stat_type;

   // a = m[o][d], b = m[d][r], c = m[o][r]; 1 is +1, 0 is -1
   function automatic logic apply_rule(rule_type rule, logic a, logic b, logic c);
      logic v;
      case (rule)
         RULE_4:  v = b ? (a | c) : ~c;
         RULE_6:  v = ~(b ^ c);
         RULE_7:  v = b ? (a | c) : (a & ~c);
         RULE_8:  v = b ? c : (a & ~c);
         default: v = a;
      endcase
      return v;
   endfunction

endpackage

>>> design/signed_network_rule_update.sv
// top level of the signed network rule update block
//
//  channel   ports                            transfer
//  request   start, busy, req_data            start & !busy
//  response  rsp_valid, rsp_data              rsp_valid, one cycle, no backpressure
//  config    csr_valid, csr_ready, csr_data   csr_valid & csr_ready
//
// write, read and unknown requests answer from the execute state through the response register
// a step answers after its column update and a scan of up to NODES*NODES (d, r) pairs, one pair per cycle through
//   the shared row port and the row evaluators, stopping at the first changing triple
// busy goes high after a request is accepted and stays high until the response cycle; the next request may start then
// reset clears the matrix to all -1 and selects rule 4
module signed_network_rule_update #(
   parameter int NODES = snru_pkg::NODES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  snru_pkg::req_type             req_data,
   output logic                          rsp_valid,
   output snru_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [snru_pkg::RULE_W-1:0]   csr_data
);

   snru_pkg::rule_type      rule_ff;
   snru_pkg::lane_ctrl_type ctrl;
   snru_pkg::lane_stat_type stat;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_ff <= snru_pkg::RULE_4;
      end else if (csr_valid && csr_ready) begin
         rule_ff <= snru_pkg::rule_type'(csr_data);
      end
   end

   snru_seq #(
      .NODES (NODES)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .rule      (rule_ff),
      .stat      (stat),
      .busy      (busy),
      .ctrl      (ctrl),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   snru_lanes #(
      .NODES (NODES)
   ) u_lanes (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .stat  (stat)
   );

endmodule

>>> design/snru_lanes.sv
// sign matrix rows with one rule evaluator per row, shared over all (d, r) pairs
module snru_lanes #(
   parameter int NODES = snru_pkg::NODES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  snru_pkg::lane_ctrl_type ctrl,
   output snru_pkg::lane_stat_type stat
);

   localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;

   logic [NODES-1:0] rows_ff [NODES];
   logic [NODES-1:0] rows_in [NODES];
   logic [IDX_W-1:0] ia;
   logic [IDX_W-1:0] ib;
   logic [NODES-1:0] sel_row;
   logic             b_bit;
   logic [NODES-1:0] new_bit;
   logic [NODES-1:0] diff;

   assign ia      = ctrl.sel_a[IDX_W-1:0];
   assign ib      = ctrl.sel_b[IDX_W-1:0];
   // one shared row port: row d for the b term, or the row being read
   assign sel_row = rows_ff[ia];
   assign b_bit   = sel_row[ib];

   always_comb begin
      rows_in = rows_ff;
      for (int o = 0; o < NODES; o++) begin
         new_bit[o] = snru_pkg::apply_rule(ctrl.rule, rows_ff[o][ia], b_bit, rows_ff[o][ib]);
         diff[o]    = new_bit[o] ^ rows_ff[o][ia];
         if (ctrl.op == snru_pkg::LANE_WRITE && IDX_W'(o) == ia) begin
            rows_in[o][ib] = ctrl.sign_bit;
         end
         if (ctrl.op == snru_pkg::LANE_UPDATE) begin
            rows_in[o][ia] = new_bit[o];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int o = 0; o < NODES; o++) begin
            rows_ff[o] <= '0;
         end
      end else begin
         rows_ff <= rows_in;
      end
   end

   assign stat.row      = snru_pkg::NODES_MAX'(sel_row);
   assign stat.mismatch = (ctrl.op == snru_pkg::LANE_CHECK) && (|diff);

endmodule

>>> design/snru_seq.sv
// request sequencer: executes writes, reads and column steps; after a step it sweeps the absorbing check
module snru_seq #(
   parameter int NODES = snru_pkg::NODES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  snru_pkg::req_type       req_data,
   input  snru_pkg::rule_type      rule,
   input  snru_pkg::lane_stat_type stat,
   output logic                    busy,
   output snru_pkg::lane_ctrl_type ctrl,
   output logic                    rsp_valid,
   output snru_pkg::rsp_type       rsp_data
);

   localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NODES - 1);
   localparam logic [snru_pkg::NODE_W:0] NODES_V = (snru_pkg::NODE_W + 1)'(NODES);

   snru_pkg::seq_state_type state_ff, state_in;
   snru_pkg::req_type       req_ff, req_in;
   logic [IDX_W-1:0]        scan_a_ff, scan_a_in;
   logic [IDX_W-1:0]        scan_b_ff, scan_b_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   snru_pkg::rsp_type       rsp_ff, rsp_in;
   logic                    a_ok;
   logic                    b_ok;
   logic                    scan_last;

   assign a_ok      = {1'b0, req_ff.node_a} < NODES_V;
   assign b_ok      = {1'b0, req_ff.node_b} < NODES_V;
   assign scan_last = (scan_a_ff == IDX_LAST) && (scan_b_ff == IDX_LAST);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         snru_pkg::SEQ_IDLE: begin
            if (start) begin
               state_in = snru_pkg::SEQ_EXEC;
            end
         end
         snru_pkg::SEQ_EXEC: begin
            if (req_ff.kind == snru_pkg::KIND_STEP) begin
               state_in = snru_pkg::SEQ_SCAN;
            end else begin
               state_in = snru_pkg::SEQ_IDLE;
            end
         end
         snru_pkg::SEQ_SCAN: begin
            if (stat.mismatch || scan_last) begin
               state_in = snru_pkg::SEQ_IDLE;
            end
         end
         default: state_in = snru_pkg::SEQ_IDLE;
      endcase
   end

   // outputs, lane control and scan counters
   always_comb begin
      req_in        = req_ff;
      scan_a_in     = scan_a_ff;
      scan_b_in     = scan_b_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = '0;
      ctrl.op       = snru_pkg::LANE_HOLD;
      ctrl.rule     = rule;
      ctrl.sel_a    = req_ff.node_a;
      ctrl.sel_b    = req_ff.node_b;
      ctrl.sign_bit = req_ff.sign_bit;
      case (state_ff)
         snru_pkg::SEQ_IDLE: begin
            if (start) begin
               req_in = req_data;
            end
         end
         snru_pkg::SEQ_EXEC: begin
            scan_a_in = '0;
            scan_b_in = '0;
            case (req_ff.kind)
               snru_pkg::KIND_WRITE: begin
                  if (a_ok && b_ok) begin
                     ctrl.op = snru_pkg::LANE_WRITE;
                  end
                  rsp_valid_in = 1'b1;
               end
               snru_pkg::KIND_STEP: begin
                  if (a_ok && b_ok) begin
                     ctrl.op = snru_pkg::LANE_UPDATE;
                  end
               end
               snru_pkg::KIND_READ: begin
                  rsp_valid_in = 1'b1;
                  if (a_ok) begin
                     rsp_in.row_bits = stat.row[snru_pkg::ROW_W-1:0];
                  end
               end
               default: rsp_valid_in = 1'b1;
            endcase
         end
         snru_pkg::SEQ_SCAN: begin
            ctrl.op    = snru_pkg::LANE_CHECK;
            ctrl.sel_a = snru_pkg::NODE_W'(scan_a_ff);
            ctrl.sel_b = snru_pkg::NODE_W'(scan_b_ff);
            if (stat.mismatch || scan_last) begin
               rsp_valid_in     = 1'b1;
               rsp_in.absorbing = ~stat.mismatch;
            end
            if (scan_b_ff == IDX_LAST) begin
               scan_b_in = '0;
               scan_a_in = scan_a_ff + 1'b1;
            end else begin
               scan_b_in = scan_b_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= snru_pkg::SEQ_IDLE;
         rsp_valid_ff <= 1'b0;
         scan_a_ff    <= '0;
         scan_b_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_a_ff    <= scan_a_in;
         scan_b_ff    <= scan_b_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != snru_pkg::SEQ_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == snru_pkg::SEQ_EXEC
                        || $past(state_ff) == snru_pkg::SEQ_SCAN))
      else $error("response without a request in progress");

   a_start_enters_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == snru_pkg::SEQ_IDLE && start) |=> state_ff == snru_pkg::SEQ_EXEC)
      else $error("accepted request did not start executing");

   a_short_req_answers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == snru_pkg::SEQ_EXEC && req_ff.kind != snru_pkg::KIND_STEP)
      |=> rsp_valid_ff && state_ff == snru_pkg::SEQ_IDLE)
      else $error("write, read or unknown request not answered next cycle");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == snru_pkg::SEQ_SCAN |-> (scan_a_ff <= IDX_LAST && scan_b_ff <= IDX_LAST))
      else $error("absorbing scan index out of range");

endmodule
